// ----- rtl/core/damage_rect_list_merger_assert.svh -----
// Assertion macros for the damage rectangle list merger.
// Used by the top level only.
`ifndef DAMAGE_RECT_LIST_MERGER_ASSERT_SVH
`define DAMAGE_RECT_LIST_MERGER_ASSERT_SVH
`ifndef SYNTHESIS
`define DRLM_ASSERT_IMPL(label, clk, rst, a, c) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) else $error("%m fail");
`define DRLM_ASSERT_NEXT(label, clk, rst, a, c) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) else $error("%m fail");
`else
`define DRLM_ASSERT_IMPL(label, clk, rst, a, c)
`define DRLM_ASSERT_NEXT(label, clk, rst, a, c)
`endif
`endif

// ----- rtl/core/drlm_pkg.sv -----
// Shared types and constants of the damage rectangle list merger.
// No dependencies.
package drlm_pkg;
  localparam int MAX_RECTS = 16;
  localparam int IDX_W = $clog2(MAX_RECTS);
  localparam int CNT_W = $clog2(MAX_RECTS + 1);
  localparam int CW = 15;
  localparam int AW = 2 * CW + 1;

  localparam logic [1:0] OP_MARK = 2'd0;
  localparam logic [1:0] OP_DRAIN = 2'd1;
  localparam logic [1:0] OP_DISCARD = 2'd2;

  localparam logic [2:0] ST_REJECT = 3'd0;
  localparam logic [2:0] ST_APPEND = 3'd1;
  localparam logic [2:0] ST_FOLD = 3'd2;
  localparam logic [2:0] ST_READOUT = 3'd3;
  localparam logic [2:0] ST_EMPTY = 3'd4;

  localparam logic CFG_WIDTH = 1'b0;
  localparam logic CFG_HEIGHT = 1'b1;

  typedef struct packed {
    logic [CW-1:0] x0;
    logic [CW-1:0] y0;
    logic [CW-1:0] x1;
    logic [CW-1:0] y1;
  } rect_t;

  typedef struct packed {
    logic load_in;     // clip and latch input rectangle
    logic rd;          // read entry at idx
    logic [IDX_W-1:0] idx;
    logic eval;        // evaluate entry read last cycle
    logic absorb;      // r := union(r, rd_data)
    logic best_clr;
    logic wr_r;        // write r at idx
    logic wr_last;     // write last-read entry at idx
    logic wr_fold;     // write union(r, best-read entry) at idx
  } dp_cmd_t;

  typedef struct packed {
    logic reject;
    logic cheap;
    logic [IDX_W-1:0] best;
    rect_t rd_rect;
  } dp_stat_t;

  function automatic logic [AW-1:0] area(rect_t r);
    logic [CW-1:0] dx;
    logic [CW-1:0] dy;
    dx = r.x1 - r.x0;
    dy = r.y1 - r.y0;
    return AW'(dx) * AW'(dy);
  endfunction

  function automatic rect_t runion(rect_t a, rect_t b);
    rect_t u;
    u.x0 = a.x0 < b.x0 ? a.x0 : b.x0;
    u.y0 = a.y0 < b.y0 ? a.y0 : b.y0;
    u.x1 = a.x1 > b.x1 ? a.x1 : b.x1;
    u.y1 = a.y1 > b.y1 ? a.y1 : b.y1;
    return u;
  endfunction
endpackage

// ----- rtl/core/drlm_ram.sv -----
// Generic simple dual-port RAM (one write port, one read port) with registered read.
// No dependencies.
module drlm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

// ----- rtl/core/drlm_datapath.sv -----
// Datapath: rectangle table, clip, union and area compare, best-fit tracking.
// Depends on drlm_pkg and drlm_ram.
module drlm_datapath import drlm_pkg::*; (
  input  logic            clk,
  input  logic [CW-1:0]   scr_w,
  input  logic [CW-1:0]   scr_h,
  input  logic [15:0]     left,
  input  logic [15:0]     top,
  input  logic [15:0]     span_w,
  input  logic [15:0]     span_h,
  input  dp_cmd_t         cmd,
  output dp_stat_t        stat
);
  rect_t r;
  rect_t rd_data;
  rect_t uni;
  rect_t wdata;
  logic [AW-1:0] a_u, a_e, a_r;
  logic [AW:0] sum_ae;
  logic [AW-1:0] grow;
  logic [AW-1:0] best_grow;
  logic [IDX_W-1:0] best;
  logic [IDX_W-1:0] eval_idx;
  logic best_vld;
  logic cheap;
  logic [16:0] x2, y2;
  logic [16:0] x2c, y2c;
  logic rej;
  logic reject_q;
  rect_t fold_rect;

  always_comb begin
    x2 = {1'b0, left} + {1'b0, span_w};
    y2 = {1'b0, top} + {1'b0, span_h};
    x2c = (x2 > {2'b0, scr_w}) ? {2'b0, scr_w} : x2;
    y2c = (y2 > {2'b0, scr_h}) ? {2'b0, scr_h} : y2;
    rej = (scr_w == '0) || (scr_h == '0) || (left >= {1'b0, scr_w}) ||
          (top >= {1'b0, scr_h}) || (x2c <= {1'b0, left}) || (y2c <= {1'b0, top});
  end

  always_comb begin
    uni = runion(rd_data, r);
    a_u = area(uni);
    a_e = area(rd_data);
    a_r = area(r);
    sum_ae = {1'b0, a_e} + {1'b0, a_r};
    cheap = {1'b0, a_u} <= sum_ae;
    grow = a_u - a_e;
    wdata = cmd.wr_last ? rd_data : (cmd.wr_fold ? fold_rect : r);
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      r.x0 <= left[CW-1:0];
      r.y0 <= top[CW-1:0];
      r.x1 <= x2c[CW-1:0];
      r.y1 <= y2c[CW-1:0];
      reject_q <= rej;
    end else if (cmd.absorb) begin
      r <= uni;
    end
    if (cmd.rd) eval_idx <= cmd.idx;
    if (cmd.best_clr) best_vld <= 1'b0;
    else if (cmd.eval && (!best_vld || grow < best_grow)) begin
      best_vld <= 1'b1;
      best_grow <= grow;
      best <= eval_idx;
      fold_rect <= uni;
    end
  end

  drlm_ram #(.WIDTH($bits(rect_t)), .DEPTH(MAX_RECTS)) u_tab (
    .clk(clk), .we(cmd.wr_r | cmd.wr_last | cmd.wr_fold), .waddr(cmd.idx),
    .wdata(wdata), .raddr(cmd.idx), .rdata(rd_data)
  );

  assign stat.reject = reject_q;
  assign stat.cheap = cheap;
  assign stat.best = best;
  assign stat.rd_rect = rd_data;
endmodule

// ----- rtl/core/drlm_ctrl.sv -----
// Controller: sequences marks, merge scans, fold search, drains and discards.
// Depends on drlm_pkg.
module drlm_ctrl import drlm_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  op,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  out_status,
  output rect_t       out_rect,
  output logic [CNT_W-1:0] out_count,
  output logic        out_last,
  output dp_cmd_t     cmd,
  input  dp_stat_t    stat
);
  typedef enum logic [3:0] {
    S_IDLE, S_CHECK, S_SCAN_RD, S_SCAN_EV, S_MV_RD, S_MV_WR, S_APPEND,
    S_FOLD_RD, S_FOLD_EV, S_FOLD_WR, S_DR_RD, S_DR_OUT, S_OUT
  } state_t;

  state_t state;
  logic [CNT_W-1:0] count, n, i;
  logic [IDX_W-1:0] hit_idx;

  assign in_ready = (state == S_IDLE) && !out_valid;

  always_comb begin
    cmd = '0;
    cmd.idx = i[IDX_W-1:0];
    unique case (state)
      S_IDLE: begin
        cmd.load_in = in_valid && in_ready;
        cmd.best_clr = 1'b1;
      end
      S_SCAN_RD, S_FOLD_RD, S_DR_RD: cmd.rd = 1'b1;
      S_SCAN_EV: cmd.absorb = stat.cheap;
      S_MV_RD: begin
        cmd.rd = 1'b1;
        cmd.idx = n[IDX_W-1:0];
      end
      S_MV_WR: begin
        cmd.wr_last = 1'b1;
        cmd.idx = hit_idx;
      end
      S_APPEND: begin
        cmd.wr_r = 1'b1;
        cmd.idx = n[IDX_W-1:0];
      end
      S_FOLD_EV: cmd.eval = 1'b1;
      S_FOLD_WR: begin
        cmd.wr_fold = 1'b1;
        cmd.idx = stat.best;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
      out_valid <= 1'b0;
    end else begin
      // output states reload the beat themselves when it is taken
      if (out_valid && out_ready && (state != S_DR_OUT) && (state != S_OUT))
        out_valid <= 1'b0;
      unique case (state)
        S_IDLE: if (in_valid && in_ready) begin
          out_rect <= '0;
          out_last <= 1'b1;
          i <= '0;
          n <= count;
          priority case (op)
            OP_MARK: state <= S_CHECK;
            OP_DRAIN: begin
              if (count == '0) begin
                out_status <= ST_EMPTY;
                out_count <= '0;
                out_valid <= 1'b1;
              end else state <= S_DR_RD;
              count <= '0;
            end
            OP_DISCARD: begin
              count <= '0;
              out_status <= ST_EMPTY;
              out_count <= '0;
              out_valid <= 1'b1;
            end
            default: begin
              out_status <= ST_REJECT;
              out_count <= count;
              out_valid <= 1'b1;
            end
          endcase
        end
        S_CHECK: begin
          if (stat.reject) begin
            out_status <= ST_REJECT;
            out_count <= count;
            state <= S_OUT;
          end else state <= (n == '0) ? S_APPEND : S_SCAN_RD;
        end
        S_SCAN_RD: state <= S_SCAN_EV;
        S_SCAN_EV: begin
          if (stat.cheap) begin
            hit_idx <= i[IDX_W-1:0];
            n <= n - 1'b1;
            state <= S_MV_RD;
          end else if (i + 1'b1 == n) begin
            state <= (n < CNT_W'(MAX_RECTS)) ? S_APPEND : S_FOLD_RD;
            i <= '0;
          end else begin
            i <= i + 1'b1;
            state <= S_SCAN_RD;
          end
        end
        S_MV_RD: state <= S_MV_WR;
        S_MV_WR: begin
          i <= '0;
          state <= (n == '0) ? S_APPEND : S_SCAN_RD;
        end
        S_APPEND: begin
          count <= n + 1'b1;
          out_status <= ST_APPEND;
          out_count <= n + 1'b1;
          state <= S_OUT;
        end
        S_FOLD_RD: state <= S_FOLD_EV;
        S_FOLD_EV: begin
          if (i + 1'b1 == n) state <= S_FOLD_WR;
          else begin
            i <= i + 1'b1;
            state <= S_FOLD_RD;
          end
        end
        S_FOLD_WR: begin
          count <= n;
          out_status <= ST_FOLD;
          out_count <= n;
          state <= S_OUT;
        end
        S_DR_RD: state <= S_DR_OUT;
        S_DR_OUT: if (!out_valid || out_ready) begin
          out_status <= ST_READOUT;
          out_rect <= stat.rd_rect;
          out_count <= '0;
          out_last <= (i + 1'b1 == n);
          out_valid <= 1'b1;
          i <= i + 1'b1;
          state <= (i + 1'b1 == n) ? S_IDLE : S_DR_RD;
        end
        S_OUT: if (!out_valid || out_ready) begin
          out_rect <= '0;
          out_last <= 1'b1;
          out_valid <= 1'b1;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule

// ----- rtl/core/damage_rect_list_merger.sv -----
// Top level of the damage rectangle list merger.
// Depends on drlm_pkg, drlm_ctrl, drlm_datapath and the assertion header.
//
//  channel | dir | beat
//  s_axis  | in  | tdata = op, left, top, span_w, span_h
//  m_axis  | out | tdata = status, x0, y0, x1, y1, entry_count; tlast = last
//  cfg     | in  | we, index, data (screen_width, screen_height)
//
// Each entry test is a RAM read then a compare. A mark is checked for
// rejection, then scans the entries on each merge pass, moves the last entry
// into the slot of each absorbed one, and on a full table runs a fold search;
// a drain reads then outputs each entry; an empty drain, a discard or a spare op
// is answered from idle. Reset clears the count and control; the table needs no clearing.
// A stalled output holds the sequencer; no input is taken until delivered.
`include "damage_rect_list_merger_assert.svh"
module damage_rect_list_merger import drlm_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [71:0] s_axis_tdata,  // op[1:0], left, top, span_w, span_h
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [71:0] m_axis_tdata,  // status[2:0], x0, y0, x1, y1, entry_count
  output logic        m_axis_tlast,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [14:0] cfg_data
);
  logic [CW-1:0] scr_w, scr_h;
  dp_cmd_t cmd;
  dp_stat_t stat;
  logic [2:0] st;
  rect_t rr;
  logic [CNT_W-1:0] cnt;

  always_ff @(posedge clk) begin
    if (rst) begin
      scr_w <= '0;
      scr_h <= '0;
    end else if (cfg_we) begin
      if (cfg_index == CFG_WIDTH) scr_w <= cfg_data;
      else scr_h <= cfg_data;
    end
  end

  drlm_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
    .op(s_axis_tdata[1:0]), .out_valid(m_axis_tvalid), .out_ready(m_axis_tready),
    .out_status(st), .out_rect(rr), .out_count(cnt), .out_last(m_axis_tlast),
    .cmd(cmd), .stat(stat)
  );

  drlm_datapath u_dp (
    .clk(clk), .scr_w(scr_w), .scr_h(scr_h), .left(s_axis_tdata[17:2]),
    .top(s_axis_tdata[33:18]), .span_w(s_axis_tdata[49:34]),
    .span_h(s_axis_tdata[65:50]), .cmd(cmd), .stat(stat)
  );

  assign m_axis_tdata = {4'b0, cnt, rr.y1, rr.x1, rr.y0, rr.x0, st};

  `DRLM_ASSERT_IMPL(a_no_accept_busy, clk, rst, m_axis_tvalid, !s_axis_tready)
  `DRLM_ASSERT_IMPL(a_cnt_range, clk, rst, m_axis_tvalid, cnt <= CNT_W'(MAX_RECTS))
  `DRLM_ASSERT_NEXT(a_accept_drops_ready, clk, rst, s_axis_tvalid && s_axis_tready, !s_axis_tready)
endmodule

// ----- verif/tb.sv -----
// Self-checking testbench for damage_rect_list_merger.
// Depends on drlm_pkg and the RTL; a built-in predictor checks every output beat.
module tb;
  import drlm_pkg::*;

  localparam logic [1:0] OP_SPARE = 2'd3;
  localparam int STALL_LIMIT = 20000;

  typedef struct {
    logic [2:0]  status;
    logic [14:0] x0, y0, x1, y1;
    logic [4:0]  count;
    logic        last;
  } beat_t;

  typedef struct {
    int unsigned x0, y0, x1, y1;
  } box_t;

  logic        clk = 0;
  logic        rst = 1;
  logic        s_axis_tvalid = 0;
  logic        s_axis_tready;
  logic [71:0] s_axis_tdata = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 0;
  logic [71:0] m_axis_tdata;
  logic        m_axis_tlast;
  logic        cfg_we = 0;
  logic        cfg_index = 0;
  logic [14:0] cfg_data = '0;

  box_t        boxes[MAX_RECTS];
  int unsigned box_total;
  int unsigned scr_w, scr_h;
  beat_t       pending_beats[$];
  int          errors, items_sent, beats_seen, stall_cycles;
  bit          steady, hold_req;
  int          hold_left;

  always #10 clk = ~clk;

  damage_rect_list_merger dut (.*);

  function automatic longint unsigned box_area(box_t b);
    return longint'(b.x1 - b.x0) * longint'(b.y1 - b.y0);
  endfunction

  function automatic box_t box_union(box_t a, box_t b);
    box_t u;
    u.x0 = a.x0 < b.x0 ? a.x0 : b.x0;
    u.y0 = a.y0 < b.y0 ? a.y0 : b.y0;
    u.x1 = a.x1 > b.x1 ? a.x1 : b.x1;
    u.y1 = a.y1 > b.y1 ? a.y1 : b.y1;
    return u;
  endfunction

  function automatic logic [2:0] merge_mark(int unsigned x, int unsigned y,
                                            int unsigned w, int unsigned h);
    box_t r, u;
    int unsigned n, best;
    longint unsigned g, best_grow;
    bit hit;
    if (scr_w == 0 || scr_h == 0 || x >= scr_w || y >= scr_h) return ST_REJECT;
    r.x0 = x;
    r.y0 = y;
    r.x1 = (x + w > scr_w) ? scr_w : x + w;
    r.y1 = (y + h > scr_h) ? scr_h : y + h;
    if (r.x1 <= r.x0 || r.y1 <= r.y0) return ST_REJECT;
    n = box_total;
    do begin
      hit = 0;
      for (int i = 0; i < n; i++) begin
        u = box_union(boxes[i], r);
        if (box_area(u) <= box_area(boxes[i]) + box_area(r)) begin
          r = u;
          n--;
          boxes[i] = boxes[n];
          hit = 1;
          break;
        end
      end
    end while (hit);
    if (n < MAX_RECTS) begin
      boxes[n] = r;
      box_total = n + 1;
      return ST_APPEND;
    end
    best = 0;
    best_grow = '1;
    for (int i = 0; i < n; i++) begin
      g = box_area(box_union(boxes[i], r)) - box_area(boxes[i]);
      if (g < best_grow) begin
        best_grow = g;
        best = i;
      end
    end
    boxes[best] = box_union(boxes[best], r);
    box_total = n;
    return ST_FOLD;
  endfunction

  function automatic beat_t mk_beat(logic [2:0] st, logic last);
    beat_t b;
    b = '{st, 0, 0, 0, 0, box_total[4:0], last};
    return b;
  endfunction

  task automatic predict_item(logic [1:0] op, logic [15:0] l, logic [15:0] t,
                              logic [15:0] w, logic [15:0] h);
    beat_t b;
    int unsigned n;
    case (op)
      OP_MARK: begin
        b.status = merge_mark(32'(l), 32'(t), 32'(w), 32'(h));
        pending_beats.push_back(mk_beat(b.status, 1));
      end
      OP_DRAIN: begin
        n = box_total;
        box_total = 0;
        if (n == 0) pending_beats.push_back(mk_beat(ST_EMPTY, 1));
        for (int i = 0; i < n; i++) begin
          b = mk_beat(ST_READOUT, i + 1 == n);
          b.x0 = boxes[i].x0[14:0];
          b.y0 = boxes[i].y0[14:0];
          b.x1 = boxes[i].x1[14:0];
          b.y1 = boxes[i].y1[14:0];
          pending_beats.push_back(b);
        end
      end
      OP_DISCARD: begin
        box_total = 0;
        pending_beats.push_back(mk_beat(ST_EMPTY, 1));
      end
      default: pending_beats.push_back(mk_beat(ST_REJECT, 1));
    endcase
  endtask

  task automatic send_item(logic [1:0] op, logic [15:0] l = 0, logic [15:0] t = 0,
                           logic [15:0] w = 0, logic [15:0] h = 0);
    s_axis_tdata <= {6'b0, h, w, t, l, op};
    s_axis_tvalid <= 1;
    do @(posedge clk); while (!s_axis_tready);
    predict_item(op, l, t, w, h);
    items_sent++;
    if (!steady && $urandom_range(99) < 30) begin
      s_axis_tvalid <= 0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
  endtask

  task automatic settle;
    s_axis_tvalid <= 0;
    @(posedge clk);
    while (pending_beats.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_reg(logic idx, logic [14:0] val);
    cfg_we <= 1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    if (idx == CFG_WIDTH) scr_w = 32'(val);
    else scr_h = 32'(val);
  endtask

  task automatic set_screen(logic [14:0] w, logic [14:0] h);
    settle();
    write_reg(CFG_WIDTH, w);
    write_reg(CFG_HEIGHT, h);
    cfg_we <= 0;
  endtask

  task automatic flag_mismatch(string what, int got, int want);
    $display("mismatch at beat %0d: %s got %0d want %0d", beats_seen, what, got, want);
    errors++;
  endtask

  // output beat checker
  always @(posedge clk) begin
    beat_t e;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      beats_seen++;
      if (pending_beats.size() == 0) begin
        $display("unexpected beat %0d: status %0d", beats_seen, m_axis_tdata[2:0]);
        errors++;
      end else begin
        e = pending_beats.pop_front();
        if (m_axis_tdata[2:0] !== e.status) flag_mismatch("status", m_axis_tdata[2:0], e.status);
        if (m_axis_tdata[17:3] !== e.x0) flag_mismatch("x0", m_axis_tdata[17:3], e.x0);
        if (m_axis_tdata[32:18] !== e.y0) flag_mismatch("y0", m_axis_tdata[32:18], e.y0);
        if (m_axis_tdata[47:33] !== e.x1) flag_mismatch("x1", m_axis_tdata[47:33], e.x1);
        if (m_axis_tdata[62:48] !== e.y1) flag_mismatch("y1", m_axis_tdata[62:48], e.y1);
        if (m_axis_tdata[67:63] !== e.count) flag_mismatch("count", m_axis_tdata[67:63], e.count);
        if (m_axis_tlast !== e.last) flag_mismatch("last", m_axis_tlast, e.last);
      end
    end
  end

  // sink with random stalls and an occasional long hold-off
  always @(posedge clk) begin
    if (rst) begin
      m_axis_tready <= 0;
    end else if (hold_req || hold_left > 0) begin
      if (hold_req) begin
        hold_left = 400;
        hold_req = 0;
      end
      hold_left--;
      m_axis_tready <= 0;
    end else begin
      m_axis_tready <= steady || $urandom_range(99) >= 30;
    end
  end

  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      stall_cycles = 0;
    else if (++stall_cycles >= STALL_LIMIT) begin
      $display("timeout: no beat for %0d cycles", STALL_LIMIT);
      $display("Regression FAIL");
      $finish;
    end
  end

  task automatic test_unset_screen;
    send_item(OP_MARK, 0, 0, 10, 10);
    send_item(OP_DRAIN);
    send_item(OP_DISCARD);
    send_item(OP_SPARE, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
  endtask

  task automatic test_clipping;
    set_screen(640, 480);
    send_item(OP_MARK, 0, 0, 16'hFFFF, 16'hFFFF);
    send_item(OP_MARK, 640, 0, 5, 5);
    send_item(OP_MARK, 0, 480, 5, 5);
    send_item(OP_MARK, 16'hFFFF, 16'hFFFF, 1, 1);
    send_item(OP_MARK, 10, 10, 0, 5);
    send_item(OP_MARK, 10, 10, 5, 0);
    send_item(OP_MARK, 639, 479, 16'hFFFF, 16'hFFFF);
    send_item(OP_DRAIN);
    send_item(OP_MARK, 100, 100, 20, 20);
    send_item(OP_MARK, 110, 110, 20, 20);
    send_item(OP_MARK, 300, 300, 10, 10);
    send_item(OP_MARK, 105, 105, 2, 2);
    send_item(OP_DRAIN);
    send_item(OP_DRAIN);
    send_item(OP_MARK, 1, 1, 3, 3);
    send_item(OP_DISCARD);
    send_item(OP_SPARE, 5, 5, 5, 5);
  endtask

  task automatic test_table_full;
    for (int i = 0; i < 19; i++) send_item(OP_MARK, 16'(4 * i), 16'(2 * (i % 3)), 1, 1);
    send_item(OP_DRAIN);
  endtask

  task automatic test_screen_extremes;
    set_screen(16384, 16384);
    send_item(OP_MARK, 16383, 16383, 16'hFFFF, 16'hFFFF);
    send_item(OP_MARK, 0, 0, 16384, 16384);
    send_item(OP_MARK, 16384, 0, 1, 1);
    send_item(OP_DRAIN);
    set_screen(15'h7FFF, 15'h7FFF);
    send_item(OP_MARK, 16'h7FFE, 16'h7FFE, 16'hFFFF, 16'hFFFF);
    send_item(OP_MARK, 16'h8000, 0, 1, 1);
    send_item(OP_DRAIN);
    set_screen(1, 0);
    send_item(OP_MARK, 0, 0, 1, 1);
    set_screen(1, 1);
    send_item(OP_MARK, 0, 0, 1, 1);
    send_item(OP_MARK, 0, 0, 16'hFFFF, 1);
    send_item(OP_DRAIN);
  endtask

  task automatic test_backpressure;
    set_screen(200, 200);
    hold_req = 1;
    for (int i = 0; i < 12; i++) send_item(OP_MARK, 16'(15 * i), 16'(7 * i), 3, 3);
    send_item(OP_DRAIN);
  endtask

  task automatic test_random(int count, logic [14:0] w, logic [14:0] h);
    int k;
    set_screen(w, h);
    for (int i = 0; i < count; i++) begin
      steady = (i >= count / 3 && i < count / 3 + 20);
      k = $urandom_range(99);
      if (k < 45)
        send_item(OP_MARK, 16'($urandom_range(0, w + 8)), 16'($urandom_range(0, h + 8)),
                  16'($urandom_range(0, 30)), 16'($urandom_range(0, 30)));
      else if (k < 65)
        send_item(OP_MARK, 16'($urandom_range(0, w)), 16'($urandom_range(0, h)),
                  16'($urandom_range(1, 3)), 16'($urandom_range(1, 3)));
      else if (k < 72)
        send_item(OP_MARK, 16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
      else if (k < 87) send_item(OP_DRAIN);
      else if (k < 94) send_item(OP_DISCARD);
      else send_item(OP_SPARE, 16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
    end
    steady = 0;
    send_item(OP_DRAIN);
  endtask

  initial begin
    steady = 0;
    hold_req = 0;
    hold_left = 0;
    box_total = 0;
    scr_w = 0;
    scr_h = 0;
    repeat (2) @(posedge clk);
    rst <= 0;
    @(posedge clk);
    test_unset_screen();
    test_clipping();
    test_table_full();
    test_screen_extremes();
    test_backpressure();
    test_random(25, 96, 64);
    test_random(20, 40, 200);
    settle();
    $display("%0d items sent, %0d beats checked: clipping, merging, full-table folds,",
             items_sent, beats_seen);
    $display("drain/discard, spare op, screen extremes and a long output hold-off");
    if (errors == 0 && pending_beats.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end
endmodule
